### hdl/assert_macros.svh
// Assertion macros used by the checker of the RTP packetizer.
// No dependencies; each macro expects signals named clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, checked at every rising edge outside reset.
`define ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

### hdl/rtpp_pkg.sv
// Shared types, constants and the header byte function of the RTP packetizer.
// No dependencies; used by the configuration registers and the top level.
`timescale 1ns / 1ps

package rtpp_pkg;

  // Longest frame accepted; longer lengths are cut to this value.
  localparam logic [23:0] MAX_FRAME_BYTES = 24'd65535;

  localparam logic [15:0] HDR_BYTES      = 16'd12;
  localparam logic [3:0]  HDR_LAST_IDX   = 4'd12;
  localparam logic [7:0]  RTP_VERSION_B0 = 8'h80;
  localparam logic [15:0] DEFAULT_UNIT   = 16'd1200;
  localparam logic [15:0] MIN_UNIT       = 16'd13;
  localparam logic [15:0] DEFAULT_MAX_PK = 16'd65535;

  // Configuration register indexes.
  localparam logic [7:0] REG_PT_CODE  = 8'd0;
  localparam logic [7:0] REG_SSRC     = 8'd1;
  localparam logic [7:0] REG_MAX_UNIT = 8'd2;
  localparam logic [7:0] REG_PKT_CAP  = 8'd3;

  typedef struct packed {
    logic [6:0]  pt_code;
    logic [31:0] ssrc;
    logic [15:0] max_unit;
    logic [15:0] pkt_cap;
  } cfg_t;

  // Byte idx of the 12-byte RTP header, multi-byte fields big endian.
  function automatic logic [7:0] hdr_byte(input logic [3:0]  idx,
                                          input logic        marker,
                                          input logic [6:0]  pt,
                                          input logic [15:0] seq,
                                          input logic [31:0] ts,
                                          input logic [31:0] ssrc);
    logic [7:0] b;
    case (idx)
      4'd0:    b = RTP_VERSION_B0;
      4'd1:    b = {marker, pt};
      4'd2:    b = seq[15:8];
      4'd3:    b = seq[7:0];
      4'd4:    b = ts[31:24];
      4'd5:    b = ts[23:16];
      4'd6:    b = ts[15:8];
      4'd7:    b = ts[7:0];
      4'd8:    b = ssrc[31:24];
      4'd9:    b = ssrc[23:16];
      4'd10:   b = ssrc[15:8];
      4'd11:   b = ssrc[7:0];
      default: b = 8'h00;
    endcase
    return b;
  endfunction

endpackage

### hdl/rtpp_cfg_regs.sv
// Configuration register file of the RTP packetizer.
// Depends on rtpp_pkg for the register indexes and the cfg_t bundle.
`timescale 1ns / 1ps

module rtpp_cfg_regs (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [7:0]         cfg_index,
  input  logic [31:0]        cfg_data,
  output rtpp_pkg::cfg_t     cfg
);

  logic [15:0] unit_wr;

  assign cfg_ready = 1'b1;

  // A unit size of zero selects the default; anything below the minimum is raised.
  always_comb begin
    if (cfg_data[15:0] == 16'd0) begin
      unit_wr = rtpp_pkg::DEFAULT_UNIT;
    end else if (cfg_data[15:0] < rtpp_pkg::MIN_UNIT) begin
      unit_wr = rtpp_pkg::MIN_UNIT;
    end else begin
      unit_wr = cfg_data[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.pt_code  <= 7'd0;
      cfg.ssrc     <= 32'd0;
      cfg.max_unit <= rtpp_pkg::DEFAULT_UNIT;
      cfg.pkt_cap  <= rtpp_pkg::DEFAULT_MAX_PK;
    end else if (cfg_valid) begin
      case (cfg_index)
        rtpp_pkg::REG_PT_CODE:  cfg.pt_code  <= cfg_data[6:0];
        rtpp_pkg::REG_SSRC:     cfg.ssrc     <= cfg_data;
        rtpp_pkg::REG_MAX_UNIT: cfg.max_unit <= unit_wr;
        rtpp_pkg::REG_PKT_CAP:  cfg.pkt_cap  <= cfg_data[15:0];
        default:                ;
      endcase
    end
  end

endmodule

### hdl/rtp_packetizer.sv
// A payload byte that needs no header passes from the item register to the output register;
// a byte that opens a packet is preceded by 12 header bytes.
// Throughput: one frame byte per cycle while m_tready is high, with each packet header
// also taking the single output byte lane. Dropped bytes complete without waiting for the output.
// Reset (rst, synchronous, active high) clears the stream state, empties both stages
// and restores the register defaults.
`timescale 1ns / 1ps

// Top level of the RTP packetizer: item register, packet state, output register.
// Depends on rtpp_pkg and rtpp_cfg_regs.
module rtp_packetizer (
  input  logic        clk,
  input  logic        rst,
  // Input stream.
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [55:0] s_tdata,   // data_byte[7:0], frame_length[23:8], frame_timestamp[55:24]
  input  logic        s_tuser,   // frame_start
  // Output stream.
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [23:0] m_tdata,   // out_byte[7:0], current_sequence[23:8]
  output logic [1:0]  m_tuser,   // packet_first[0], run_last[1]
  output logic        m_tlast,   // packet_last
  // Configuration write channel.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  rtpp_pkg::cfg_t cfg;

  rtpp_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Item register: holds one input transaction until all of its bytes have left.
  logic        itm_valid;
  logic [7:0]  itm_data;
  logic        itm_fs;
  logic [15:0] itm_len;
  logic [31:0] itm_ts;

  // Stream state, updated once per item when the item completes (idx also steps per header byte).
  logic [15:0] seq;
  logic [15:0] fbl;
  logic [15:0] pbl;
  logic [15:0] pe;
  logic [31:0] lts;
  logic [3:0]  idx;   // header bytes already sent for the current item

  // Output register.
  logic        out_valid;
  logic [7:0]  out_byte;
  logic        out_first;
  logic        out_last;
  logic        out_run;
  logic [15:0] out_seq;

  // State as seen by this item once a frame start has been applied.
  logic [15:0] len_c;
  logic [15:0] eff_fbl;
  logic [15:0] eff_pbl;
  logic [15:0] eff_pe;
  logic [15:0] eff_seq;
  logic [31:0] eff_ts;
  logic [15:0] room;
  logic        need_hdr;
  logic        last_pkt;
  logic        emit;
  logic        hdr_phase;
  logic [15:0] pbl_next;
  logic        out_load;
  logic        finish;
  logic        in_take;
  logic [7:0]  byte_next;

  always_comb begin
    if ({8'd0, itm_len} > rtpp_pkg::MAX_FRAME_BYTES) begin
      len_c = rtpp_pkg::MAX_FRAME_BYTES[15:0];
    end else begin
      len_c = itm_len;
    end

    // A new frame abandons any open packet; its sequence number counts as used.
    eff_fbl = itm_fs ? len_c : fbl;
    eff_pbl = itm_fs ? 16'd0 : pbl;
    eff_pe  = itm_fs ? 16'd0 : pe;
    eff_seq = (itm_fs && (pbl != 16'd0)) ? seq + 16'd1 : seq;
    eff_ts  = itm_fs ? itm_ts : lts;

    room     = cfg.max_unit - rtpp_pkg::HDR_BYTES;
    need_hdr = (eff_pbl == 16'd0);
    last_pkt = (eff_fbl <= room);

    // Nothing is sent outside a frame or once the packet limit is used up.
    emit = (eff_fbl != 16'd0) && !(need_hdr && (eff_pe >= cfg.pkt_cap));

    if (need_hdr) begin
      pbl_next = (last_pkt ? eff_fbl : room) - 16'd1;
    end else begin
      pbl_next = eff_pbl - 16'd1;
    end

    hdr_phase = need_hdr && (idx != rtpp_pkg::HDR_LAST_IDX);
    out_load  = itm_valid && emit && (!out_valid || m_tready);
    finish    = itm_valid && (!emit || (!hdr_phase && out_load));
    in_take   = s_tvalid && s_tready;

    if (hdr_phase) begin
      byte_next = rtpp_pkg::hdr_byte(idx, last_pkt, cfg.pt_code, eff_seq,
                                     eff_ts, cfg.ssrc);
    end else begin
      byte_next = itm_data;
    end
  end

  // A new item enters as soon as the current one completes, in the same cycle.
  assign s_tready = !itm_valid || finish;

  always_ff @(posedge clk) begin
    if (rst) begin
      itm_valid <= 1'b0;
    end else if (in_take) begin
      itm_valid <= 1'b1;
    end else if (finish) begin
      itm_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      itm_data <= s_tdata[7:0];
      itm_len  <= s_tdata[23:8];
      itm_ts   <= s_tdata[55:24];
      itm_fs   <= s_tuser;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seq <= 16'd0;
      fbl <= 16'd0;
      pbl <= 16'd0;
      pe  <= 16'd0;
      lts <= 32'd0;
      idx <= 4'd0;
    end else begin
      if (out_load && hdr_phase) begin
        idx <= idx + 4'd1;
      end
      if (finish) begin
        idx <= 4'd0;
        lts <= eff_ts;
        pe  <= eff_pe;
        seq <= eff_seq;
        pbl <= eff_pbl;
        fbl <= eff_fbl;
        if (emit) begin
          fbl <= eff_fbl - 16'd1;
          pbl <= pbl_next;
          if (need_hdr) begin
            pe <= eff_pe + 16'd1;
          end
          if (pbl_next == 16'd0) begin
            seq <= eff_seq + 16'd1;
          end
        end else if (eff_fbl != 16'd0) begin
          // Packet limit reached: the byte is consumed silently.
          fbl <= eff_fbl - 16'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_byte  <= byte_next;
      out_first <= hdr_phase && (idx == 4'd0);
      out_last  <= !hdr_phase && (pbl_next == 16'd0);
      out_run   <= !hdr_phase;
      out_seq   <= eff_seq;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {out_seq, out_byte};
  assign m_tuser  = {out_run, out_first};
  assign m_tlast  = out_last;

endmodule

### hdl/rtpp_checker.sv
// Port-level checker for the RTP packetizer, bound to the top level.
// Depends on assert_macros.svh; watches the output stream only.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rtpp_checker (
  input logic        clk,
  input logic        rst,
  input logic        m_tvalid,
  input logic        m_tready,
  input logic [23:0] m_tdata,
  input logic [1:0]  m_tuser,
  input logic        m_tlast
);

  // A stalled output transaction keeps its byte.
  `ASSERT_NEXT(a_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata))

  // The first header byte is never the end of a packet or of an item.
  `ASSERT_SAME(a_first_not_end, m_tvalid && m_tuser[0], !m_tlast && !m_tuser[1])

  // A packet ends only on a payload byte, which always closes its item.
  `ASSERT_SAME(a_last_is_payload, m_tvalid && m_tlast, m_tuser[1])

  // Every packet opens with the RTP version byte.
  `ASSERT_SAME(a_version, m_tvalid && m_tuser[0], m_tdata[7:0] == 8'h80)

endmodule

bind rtp_packetizer rtpp_checker u_rtpp_checker (
  .clk      (clk),
  .rst      (rst),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser),
  .m_tlast  (m_tlast)
);
